// ===== rtl/core/sidt_pkg.sv =====
// ============================================================================
// sidt_pkg: shared types and constants for the signed integer to text block
// Holds the default sizes, the character codes, the sequencer state type and
// the status word that the conversion unit reports to the top level.
// ============================================================================
package sidt_pkg;

   // Default sizes of the top level.
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int MAX_CHARS_DEFAULT  = 11;

   // Defaults for the conversion unit, matching the top-level defaults.
   localparam int MAG_BITS_DEFAULT = VALUE_BITS_DEFAULT + 1;
   localparam int DIGITS_DEFAULT   = 10;

   // The length register after reset.
   localparam logic [3:0] MAX_LENGTH_RESET = 4'd11;

   // ASCII codes that the block sends.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Sequencer of the top level.
   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_CONVERT = 3'b010,
      ST_EMIT    = 3'b100
   } state_type;

   // Status of the conversion unit.
   typedef struct packed {
      logic busy;
      logic done;
   } conv_stat_type;

endpackage

// ===== rtl/core/sidt_dabble.sv =====
// ============================================================================
// sidt_dabble: iterative binary to BCD converter
// Shifts the magnitude in one bit per cycle, adding three to every BCD digit
// of five or more before each shift, and tracks the number of digits in use.
// ============================================================================
module sidt_dabble #(
   parameter int MAG_BITS = sidt_pkg::MAG_BITS_DEFAULT,
   parameter int DIGITS   = sidt_pkg::DIGITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [MAG_BITS-1:0]         start_mag,
   output sidt_pkg::conv_stat_type     stat,
   output logic [DIGITS-1:0][3:0]      digits,
   output logic [$clog2(DIGITS+1)-1:0] digit_count
);

   localparam int CNT_BITS  = $clog2(DIGITS + 1);
   localparam int IDX_BITS  = $clog2(DIGITS);
   localparam int LEFT_BITS = $clog2(MAG_BITS + 1);

   logic [MAG_BITS-1:0]    shift_ff;
   logic [DIGITS-1:0][3:0] bcd_ff;
   logic [DIGITS-1:0][3:0] bcd_in;
   logic [DIGITS-1:0][3:0] adj;
   logic [CNT_BITS-1:0]    count_ff;
   logic [CNT_BITS-1:0]    count_in;
   logic [LEFT_BITS-1:0]   left_ff;
   logic                   busy_ff;
   logic                   done_ff;

   // Add-three correction on every digit, then a one-bit left shift.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      for (int i = 0; i < DIGITS; i++) begin
         if (i == 0) begin
            bcd_in[i] = {adj[i][2:0], shift_ff[MAG_BITS-1]};
         end else begin
            bcd_in[i] = {adj[i][2:0], adj[i-1][3]};
         end
      end
   end

   // Doubling adds at most one digit, so only the next slot needs a look.
   always_comb begin
      count_in = count_ff;
      if (count_ff < CNT_BITS'(DIGITS)) begin
         if (bcd_in[count_ff[IDX_BITS-1:0]] != 4'd0) begin
            count_in = count_ff + CNT_BITS'(1);
         end
      end
   end

   // Control of the shift sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            left_ff <= LEFT_BITS'(MAG_BITS);
         end else if (busy_ff) begin
            left_ff <= left_ff - LEFT_BITS'(1);
            if (left_ff == LEFT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath of the shift sequence.
   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= start_mag;
         bcd_ff   <= '0;
         count_ff <= CNT_BITS'(1);
      end else if (busy_ff) begin
         shift_ff <= {shift_ff[MAG_BITS-2:0], 1'b0};
         bcd_ff   <= bcd_in;
         count_ff <= count_in;
      end
   end

   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;
   assign digits      = bcd_ff;
   assign digit_count = count_ff;

endmodule

// ===== rtl/core/signed_int_to_decimal_text.sv =====
// ============================================================================
// signed_int_to_decimal_text: signed integer to ASCII decimal text
// Converts one two's-complement word into its decimal characters, most
// significant first, with a leading minus for negatives and no leading
// zeros, cut to a programmable maximum length.
// ============================================================================
//
// Channel  Direction  Ports                              Moves
// req      in         req_valid/req_ready, req_value     one integer word
// rsp      out        rsp_valid/rsp_ready, rsp_out_char,  one character word
//                     rsp_last
// csr      in         csr_wr_en, csr_wr_data             max length, no wait
//
// Each word is sent as N characters, N being 1 to MAX_CHARS.
// The shift-and-add-three converter takes in one bit per cycle.
// req_ready is high only while the sequencer is idle; a stalled rsp side
// holds the character register and pauses the emit sequence.
// Reset clears the sequencer and sets max length to eleven.
//
module signed_int_to_decimal_text #(
   parameter int VALUE_BITS = sidt_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_CHARS  = sidt_pkg::MAX_CHARS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [3:0]            csr_wr_data
);

   localparam int MAG_BITS  = VALUE_BITS + 1;
   localparam int DIGITS    = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int CNT_BITS  = $clog2(DIGITS + 1);
   localparam int IDX_BITS  = $clog2(DIGITS);
   localparam int CHAR_BITS = $clog2(MAX_CHARS + 1);
   localparam int LEN_BITS  = $clog2(DIGITS + MAX_CHARS + 2);

   sidt_pkg::state_type     state_ff;
   sidt_pkg::conv_stat_type conv_stat;

   logic [3:0]             max_length_ff;
   logic                   neg_ff;
   logic [CHAR_BITS-1:0]   sent_ff;
   logic [CHAR_BITS-1:0]   k_ff;
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_char_ff;
   logic                   rsp_last_ff;

   logic                   accept;
   logic                   load;
   logic                   is_last;
   logic [MAG_BITS-1:0]    value_ext;
   logic [MAG_BITS-1:0]    start_mag;
   logic [DIGITS-1:0][3:0] digits;
   logic [CNT_BITS-1:0]    digit_count;
   logic [LEN_BITS-1:0]    limit;
   logic [LEN_BITS-1:0]    total;
   logic [LEN_BITS-1:0]    slot;
   logic [3:0]             digit;
   logic [7:0]             next_char;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == sidt_pkg::ST_IDLE);

   // Magnitude one bit wider than the input, so the most negative value fits.
   assign value_ext = {req_value[VALUE_BITS-1], req_value};
   assign start_mag = req_value[VALUE_BITS-1] ? (MAG_BITS'(0) - value_ext) : value_ext;

   sidt_dabble #(
      .MAG_BITS (MAG_BITS),
      .DIGITS   (DIGITS)
   ) u_dabble (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .start_mag   (start_mag),
      .stat        (conv_stat),
      .digits      (digits),
      .digit_count (digit_count)
   );

   // Length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= sidt_pkg::MAX_LENGTH_RESET;
      end else if (csr_wr_en) begin
         max_length_ff <= csr_wr_data;
      end
   end

   // Effective limit: zero counts as one, and the cap is MAX_CHARS.
   always_comb begin
      limit = LEN_BITS'(max_length_ff);
      if (limit == '0) begin
         limit = LEN_BITS'(1);
      end
      if (limit > LEN_BITS'(MAX_CHARS)) begin
         limit = LEN_BITS'(MAX_CHARS);
      end
      total = LEN_BITS'(digit_count) + LEN_BITS'(neg_ff);
   end

   // Character at emit position k: the sign first, then digits from the top.
   always_comb begin
      slot      = LEN_BITS'(digit_count) + LEN_BITS'(neg_ff) - LEN_BITS'(1)
                  - LEN_BITS'(k_ff);
      digit     = digits[slot[IDX_BITS-1:0]];
      next_char = sidt_pkg::CHAR_ZERO + {4'd0, digit};
      if (neg_ff && (k_ff == '0)) begin
         next_char = sidt_pkg::CHAR_MINUS;
      end
      is_last = ((k_ff + CHAR_BITS'(1)) == sent_ff);
      load    = (state_ff == sidt_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sidt_pkg::ST_IDLE;
      end else begin
         unique case (state_ff)
            sidt_pkg::ST_IDLE: begin
               if (accept) begin
                  state_ff <= sidt_pkg::ST_CONVERT;
               end
            end
            sidt_pkg::ST_CONVERT: begin
               if (conv_stat.done) begin
                  state_ff <= sidt_pkg::ST_EMIT;
               end
            end
            sidt_pkg::ST_EMIT: begin
               if (load && is_last) begin
                  state_ff <= sidt_pkg::ST_IDLE;
               end
            end
            default: begin
               state_ff <= sidt_pkg::ST_IDLE;
            end
         endcase
      end
   end

   // Sign, character count and emit position.
   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff <= req_value[VALUE_BITS-1];
      end
      if (conv_stat.done) begin
         sent_ff <= (total < limit) ? CHAR_BITS'(total) : CHAR_BITS'(limit);
         k_ff    <= '0;
      end else if (load) begin
         k_ff <= k_ff + CHAR_BITS'(1);
      end
   end

   // Output register: holds a character word until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_char_ff <= next_char;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   // The converter finishes only while the sequencer waits for it.
   a_done_in_convert: assert property (@(posedge clock) disable iff (reset)
      conv_stat.done |-> (state_ff == sidt_pkg::ST_CONVERT))
      else $error("converter finished outside the convert state");

   // An accepted word starts the converter in the next cycle.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> conv_stat.busy)
      else $error("accepted word did not start the converter");

   // While emitting, the position stays below the character count.
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sidt_pkg::ST_EMIT) |-> (k_ff < sent_ff))
      else $error("emit position ran past the character count");

   // The character count is between one and the cap.
   a_sent_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sidt_pkg::ST_EMIT) |->
         ((sent_ff != '0) && (sent_ff <= CHAR_BITS'(MAX_CHARS))))
      else $error("character count out of range");

endmodule

// ===== sim/decimal_text_checker.sv =====
// ----------------------------------------------------------------------------
// decimal_text_checker: predictor and scoreboard for the integer-to-text block
// Watches the request, response and length-register ports, works out the
// characters that each accepted integer word must produce, and compares every
// accepted character word against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module decimal_text_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_char,
   input  logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   output int          fail_count,
   output int          pending_chars,
   output int          values_seen,
   output int          chars_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } text_char_type;

   text_char_type expected_text[$];
   logic [3:0]    length_setting = sidt_pkg::MAX_LENGTH_RESET;
   int            fails = 0;
   int            values_count = 0;
   int            chars_count = 0;

   // Queue the text of one integer: optional minus, then the digits most
   // significant first, cut to the effective length with last on the final one.
   function automatic void predict_text(input logic [31:0] value);
      logic [32:0]   mag;
      logic          negative;
      logic [3:0]    digits[10];
      int            ndig;
      int            total;
      int            limit;
      int            sent;
      text_char_type ch;
      negative = value[31];
      // The magnitude is one bit wider, so the most negative value stays exact.
      mag = negative ? (33'd0 - {1'b1, value}) : {1'b0, value};
      ndig = 0;
      do begin
         digits[ndig] = 4'(mag % 33'd10);
         ndig++;
         mag = mag / 33'd10;
      end while (mag != 33'd0);
      total = ndig + (negative ? 1 : 0);
      // A zero limit acts as one, a limit above the character count is clipped.
      if (length_setting == 4'd0)
         limit = 1;
      else if (int'(length_setting) > sidt_pkg::MAX_CHARS_DEFAULT)
         limit = sidt_pkg::MAX_CHARS_DEFAULT;
      else
         limit = int'(length_setting);
      sent = (total < limit) ? total : limit;
      for (int k = 0; k < sent; k++) begin
         if (negative && k == 0)
            ch.code = sidt_pkg::CHAR_MINUS;
         else
            ch.code = sidt_pkg::CHAR_ZERO
                      + 8'(digits[ndig - 1 - (k - (negative ? 1 : 0))]);
         ch.last = (k + 1 == sent);
         expected_text.push_back(ch);
      end
   endfunction

   // Sample every port at the clock edge, before the design updates them.
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         expected_text.delete();
         length_setting = sidt_pkg::MAX_LENGTH_RESET;
      end else begin
         if (req_valid && req_ready) begin
            predict_text(req_value);
            values_count++;
         end
         if (rsp_valid && rsp_ready) begin
            chars_count++;
            if (expected_text.size() == 0) begin
               if (fails < 10)
                  $display("%0t checker: character word 0x%02h last=%0b with no text pending",
                           $realtime, rsp_out_char, rsp_last);
               fails++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_out_char !== want.code || rsp_last !== want.last) begin
                  if (fails < 10)
                     $display("%0t checker: expected char 0x%02h last=%0b, got 0x%02h last=%0b",
                              $realtime, want.code, want.last, rsp_out_char, rsp_last);
                  fails++;
               end
            end
         end
         // The length register takes the write at this edge.
         if (csr_wr_en)
            length_setting = csr_wr_data;
      end
      fail_count <= fails;
      pending_chars <= expected_text.size();
      values_seen <= values_count;
      chars_seen <= chars_count;
   end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the signed integer to decimal text block
// Drives integer words with random idle gaps, a long stall on the character
// side and a run of length settings; the checker beside the block predicts
// and compares every character word.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS   = 29;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_wr_data = '0;

   // Shared control of the two sides: no idling while steady is high, and
   // each increment of hold_requests asks the receiver for one long stall.
   logic        steady = 1'b0;
   int          hold_requests = 0;
   int          settings_used = 0;

   int          fail_count;
   int          pending_chars;
   int          values_seen;
   int          chars_seen;

   always #5 clock = ~clock;

   signed_int_to_decimal_text u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   decimal_text_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_chars (pending_chars),
      .values_seen   (values_seen),
      .chars_seen    (chars_seen)
   );

   // Character side: random stalls, or a long stall counted here when asked.
   initial begin
      int served;
      served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != served) begin
            served = hold_requests;
            rsp_ready <= 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++)
               @(posedge clock);
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 20);
         end
      end
   end

   // Offer one integer word and hold it until the block takes it.
   task automatic send_word(input logic [31:0] value);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random idle cycles between words, none while steady.
   task automatic idle_gap();
      int gap;
      gap = 0;
      if (!steady)
         while ($urandom_range(99) < 20)
            gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every predicted character has come back.
   // One edge first, so the count includes the word taken at the last edge.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_chars != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the length register while the block is idle.
   task automatic set_length(input logic [3:0] length);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= length;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // Mix of full-range words, extreme values, small values and words with a chosen digit count and sign.
   function automatic logic [31:0] random_value();
      int          digits;
      int          lo;
      int          hi;
      logic [31:0] mag;
      logic [31:0] extremes[7];
      extremes = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'd1000000000, -32'sd1000000000, 32'd999999999};
      case ($urandom_range(9)) inside
         [0:3]: return $urandom;
         8: return extremes[$urandom_range(6)];
         9: begin
            mag = $urandom_range(20);
            return $urandom_range(1) ? -mag : mag;
         end
         default: begin
            digits = $urandom_range(10, 1);
            lo = (digits == 1) ? 0 : 10 ** (digits - 1);
            hi = (digits == 10) ? 32'h7FFF_FFFF : 10 ** digits - 1;
            mag = $urandom_range(hi, lo);
            return $urandom_range(1) ? -mag : mag;
         end
      endcase
   endfunction

   // Stimulus: directed words, then random phases over several lengths.
   initial begin
      int          directed[15];
      logic [3:0]  lengths[10];
      directed = '{0, 1, -1, 9, 10, -10, 99, -100, 32'h7FFF_FFFF, 32'sh8000_0000,
                   1000000000, -1000000000, 1999999999, -2147483647, 123456};
      lengths  = '{4'd1, 4'd15, 4'd5, 4'd11, 4'd2, 4'd9, 4'd3, 4'd10, 4'd7, 4'd4};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset length of eleven characters.
      foreach (directed[i]) begin
         send_word(directed[i]);
         idle_gap();
      end
      drain();

      // Lengths above the character count clip to it.
      set_length(4'd12);
      send_word(32'h8000_0000);
      send_word(32'h7FFF_FFFF);
      drain();

      // A zero length still sends one character.
      set_length(4'd0);
      send_word(-32'sd5);
      send_word(32'd42);
      drain();

      // Random phases; one runs without idling, one starts with a long stall
      // on the character side while words keep coming.
      foreach (lengths[p]) begin
         set_length(lengths[p]);
         steady <= (p == 3);
         if (p == 5)
            hold_requests <= hold_requests + 1;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_word(random_value());
            idle_gap();
         end
         drain();
      end

      steady <= 1'b0;
      repeat (50) @(posedge clock);
      $display("testbench: %0d integer words converted into %0d characters",
               values_seen, chars_seen);
      $display("testbench: %0d length register writes, including zero and values above eleven",
               settings_used);
      if (fail_count == 0 && pending_chars == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   // Watchdog for a stuck handshake.
   initial begin
      #5_000_000;
      $display("testbench: timeout with %0d characters outstanding", pending_chars);
      $display("testbench: FAIL");
      $finish;
   end

endmodule
